/* hw/rtl/ps2mct_pkg.sv */
// ps2mct_pkg: shared constants and types for the ps/2 mouse cursor tracker
// no dependencies; imported by the tracker top level and referenced by its checker

package ps2mct_pkg;

  // configuration port geometry
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned CFG_W  = 13;

  // default coordinate width
  localparam int unsigned COORD_BITS_DEF = 12;

  // reset values
  localparam logic [CFG_W-1:0] SCREEN_W_RST = 13'd640;
  localparam logic [CFG_W-1:0] SCREEN_H_RST = 13'd480;
  localparam int unsigned      POS_RST      = 200;

  // header byte button bits
  localparam int unsigned LEFT_BIT  = 0;
  localparam int unsigned RIGHT_BIT = 1;

  // register index, taken from paddr bit 2
  typedef enum logic {
    REG_HSIZE = 1'b0,
    REG_VSIZE = 1'b1
  } reg_idx_e;

  // position of the next byte in its packet
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_XMOVE  = 3'b010,
    PH_YMOVE  = 3'b100
  } phase_e;

endpackage

/* hw/rtl/ps2_mouse_cursor_tracker_unit.sv */
// ps2_mouse_cursor_tracker_unit: three-byte ps/2 packet decoder with clamped cursor
// depends on ps2mct_pkg
//
// datapath: a byte is first held in the input register; the result of a third
//   packet byte is then loaded into the output register
// throughput: one byte per cycle; the input register only stalls while a
//   finished result waits in the output register and the next byte would
//   make another one
// reset: asynchronous, active low; screen 640 x 480, cursor at (200, 200),
//   packet phase back to the header byte, both registers empty

module ps2_mouse_cursor_tracker_unit #(
  parameter int unsigned COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // byte input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [COORD_BITS-1:0]          cursor_x_o,
  output logic [COORD_BITS-1:0]          cursor_y_o,
  output logic                           left_pressed_o,
  output logic                           right_pressed_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ps2mct_pkg::APB_AW-1:0]  paddr,
  input  logic [ps2mct_pkg::APB_DW-1:0]  pwdata,
  output logic [ps2mct_pkg::APB_DW-1:0]  prdata,
  output logic                           pready
);

  import ps2mct_pkg::*;

  // wide enough for both a screen size and 2^COORD_BITS
  localparam int unsigned LimW = (CFG_W > COORD_BITS + 1) ? CFG_W : COORD_BITS + 1;
  localparam int unsigned SumW = COORD_BITS + 2;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] width_q, height_q;
  reg_idx_e         reg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SCREEN_W_RST;
      height_q <= SCREEN_H_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_HSIZE: width_q  <= pwdata[CFG_W-1:0];
        REG_VSIZE: height_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (reg_idx)
      REG_HSIZE: prdata = APB_DW'(width_q);
      REG_VSIZE: prdata = APB_DW'(height_q);
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // largest legal position for a screen size: size 0 acts as 1, sizes beyond
  // the coordinate range act as 2^COORD_BITS
  // ---------------------------------------------------------------------------
  function automatic logic [COORD_BITS-1:0] max_pos(logic [CFG_W-1:0] size);
    logic [LimW-1:0] size_ext;
    logic [LimW-1:0] range;
    size_ext = LimW'(size);
    range    = LimW'(1) << COORD_BITS;
    if (size == '0) begin
      return '0;
    end else if (size_ext > range) begin
      return '1;
    end else begin
      return COORD_BITS'(size_ext - LimW'(1));
    end
  endfunction

  // position plus signed step, clamped to 0 .. maxp
  function automatic logic [COORD_BITS-1:0] clamp_move(logic [COORD_BITS-1:0] pos,
                                                       logic signed [9:0]     delta,
                                                       logic [COORD_BITS-1:0] maxp);
    logic signed [SumW-1:0] sum;
    sum = $signed({2'b00, pos}) + SumW'(delta);
    if (sum < 0) begin
      return '0;
    end else if (sum > $signed({2'b00, maxp})) begin
      return maxp;
    end else begin
      return sum[COORD_BITS-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic       in_full_q;
  logic [7:0] in_byte_q;
  logic       out_free;   // output register can take a result this cycle
  logic       proc_go;    // byte in the input register is consumed this cycle
  logic       in_take;

  phase_e     phase_q, phase_d;
  logic       makes_result;

  assign out_free     = !out_valid_o || !out_stall_i;
  assign makes_result = (phase_q == PH_YMOVE);
  assign proc_go      = in_full_q && (!makes_result || out_free);
  assign in_stall_o   = in_full_q && !proc_go;
  assign in_take      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_take) begin
      in_full_q <= 1'b1;
    end else if (proc_go) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= data_byte_i;
    end
  end

  // ---------------------------------------------------------------------------
  // packet decode and cursor update
  // ---------------------------------------------------------------------------
  logic [7:0]            header_q, header_d;
  logic [7:0]            xmove_q, xmove_d;
  logic [COORD_BITS-1:0] pos_x_q, pos_x_d;
  logic [COORD_BITS-1:0] pos_y_q, pos_y_d;
  logic signed [9:0]     dx, dy;

  assign dx = $signed({{2{xmove_q[7]}}, xmove_q});
  assign dy = -$signed({{2{in_byte_q[7]}}, in_byte_q});   // screen y grows downward

  always_comb begin
    phase_d  = phase_q;
    header_d = header_q;
    xmove_d  = xmove_q;
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    unique case (phase_q)
      PH_XMOVE: begin
        xmove_d = in_byte_q;
        phase_d = PH_YMOVE;
      end
      PH_YMOVE: begin
        pos_x_d = clamp_move(pos_x_q, dx, max_pos(width_q));
        pos_y_d = clamp_move(pos_y_q, dy, max_pos(height_q));
        phase_d = PH_HEADER;
      end
      default: begin
        // header byte; an unknown phase also restarts the packet here
        header_d = in_byte_q;
        phase_d  = PH_XMOVE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      header_q <= '0;
      xmove_q  <= '0;
      pos_x_q  <= COORD_BITS'(POS_RST);
      pos_y_q  <= COORD_BITS'(POS_RST);
    end else if (proc_go) begin
      phase_q  <= phase_d;
      header_q <= header_d;
      xmove_q  <= xmove_d;
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic out_load;

  assign out_load = proc_go && makes_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cursor_x_o      <= pos_x_d;
      cursor_y_o      <= pos_y_d;
      left_pressed_o  <= header_q[LEFT_BIT];
      right_pressed_o <= header_q[RIGHT_BIT];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/ps2mct_checker.sv */
// ps2mct_checker: port-level checks for the ps/2 mouse cursor tracker
// depends on ps2mct_pkg; bound to ps2_mouse_cursor_tracker_unit below

module ps2mct_checker #(
  parameter int unsigned COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [COORD_BITS-1:0]          cursor_x_o,
  input logic [COORD_BITS-1:0]          cursor_y_o,
  input logic                           left_pressed_o,
  input logic                           right_pressed_o
);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cursor_x_o) &&
      $stable(cursor_y_o) && $stable(left_pressed_o) && $stable(right_pressed_o))
    else $error("output word changed while stalled");

  // a word only leaves when taken
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("output word dropped without handshake");

  // input back-pressure only comes from a blocked output word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with the output free");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind ps2_mouse_cursor_tracker_unit ps2mct_checker #(
  .COORD_BITS(COORD_BITS)
) u_ps2mct_checker (.*);
